### rtl/sssp_pkg.sv
// Shared types and constants for the single-source shortest path core.
// No dependencies.
package sssp_pkg;

    localparam int unsigned NODE_BITS   = 5;
    localparam int unsigned MAX_NODES   = 32;
    localparam int unsigned WEIGHT_W    = 16;
    localparam int unsigned DIST_W      = 32;
    localparam int unsigned COUNT_W     = 6;
    localparam logic signed [DIST_W-1:0] UNREACHED_DIST = 32'sd77777;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_RUN    = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]                  action;
        logic [NODE_BITS-1:0]        from_node;
        logic [NODE_BITS-1:0]        to_node;
        logic signed [WEIGHT_W-1:0]  weight;
        logic [NODE_BITS-1:0]        source_node;
    } t_in_item;

    typedef struct packed {
        logic [NODE_BITS-1:0]        node_index;
        logic signed [DIST_W-1:0]    distance;
        logic [NODE_BITS-1:0]        predecessor;
        logic                        has_predecessor;
        logic                        reached;
        logic                        negative_cycle;
        logic                        last;
    } t_out_item;

    // Classified command handed from front to back.
    typedef struct packed {
        t_action                     act;
        logic [NODE_BITS-1:0]        from_node;
        logic [NODE_BITS-1:0]        to_node;
        logic signed [WEIGHT_W-1:0]  weight;
        logic [NODE_BITS-1:0]        source_node;
    } t_cmd;

endpackage

### rtl/sssp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sssp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/sssp_front.sv
// Front end: accepts items, drops unused actions, and feeds a two-entry queue.
// Depends on sssp_pkg.
module sssp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sssp_pkg::t_in_item i_item,
    output logic              o_busy,
    input  logic              i_pop,
    output logic              o_cmd_valid,
    output sssp_pkg::t_cmd    o_cmd
);
    import sssp_pkg::*;

    t_cmd       r_q [2];
    logic       r_rd_ptr, r_wr_ptr;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_cmd       cmd;

    assign o_busy      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign pop         = i_pop && o_cmd_valid;
    assign push        = i_start && !o_busy && (i_item.action != ACT_NONE);

    always_comb begin
        cmd.act         = t_action'(i_item.action);
        cmd.from_node   = i_item.from_node;
        cmd.to_node     = i_item.to_node;
        cmd.weight      = i_item.weight;
        cmd.source_node = i_item.source_node;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
        if (!i_rst_n) begin
            r_rd_ptr <= 1'b0;
            r_wr_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_cmd_valid)
        else $error("valid with empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> (r_cnt == 2'd2))
        else $error("full queue lost entry");
endmodule

### rtl/sssp_back.sv
// Back end: edge storage, relaxation passes, negative-cycle check, result emit.
// Depends on sssp_pkg and sssp_ram.
module sssp_back #(
    parameter int unsigned MAX_EDGES   = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sssp_pkg::COUNT_W-1:0]     i_num_nodes,
    input  logic                             i_cmd_valid,
    input  sssp_pkg::t_cmd                   i_cmd,
    output logic                             o_pop,
    output logic                             o_idle,
    output logic                             o_strobe,
    output sssp_pkg::t_out_item              o_result
);
    import sssp_pkg::*;

    localparam int unsigned EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned EC = $clog2(MAX_EDGES + 1);
    localparam int unsigned EW = 2 * NODE_BITS + WEIGHT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_READ, S_EVAL, S_EMIT
    } t_state;

    t_state r_state;
    logic [EC-1:0] r_edges;
    logic [EA-1:0] r_eidx;
    logic [COUNT_W-1:0] r_pass;
    logic [NODE_BITS-1:0] r_node;
    logic r_neg, r_check;
    logic signed [DIST_W-1:0] r_dist [MAX_NODES];
    logic [NODE_BITS-1:0] r_prev [MAX_NODES];
    logic [MAX_NODES-1:0] r_pv, r_rch;
    logic r_strobe;
    t_out_item r_result;

    logic we;
    logic [EW-1:0] rdata;
    logic [NODE_BITS-1:0] ea, eb;
    logic signed [WEIGHT_W-1:0] ew;
    logic signed [DIST_W+1:0] sum;
    logic signed [DIST_W-1:0] cand;
    logic relax;

    assign we = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.act == ACT_APPEND)
                && (r_edges < EC'(MAX_EDGES));

    sssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_edges[EA-1:0]),
        .i_wdata({i_cmd.from_node, i_cmd.to_node, i_cmd.weight}),
        .i_raddr(r_eidx),
        .o_rdata(rdata)
    );

    assign {ea, eb, ew} = rdata;
    assign sum  = (DIST_W+2)'(r_dist[ea]) + (DIST_W+2)'(ew);
    assign cand = (sum > (DIST_W+2)'(32'sh7fffffff)) ? 32'sh7fffffff :
                  (sum < -(DIST_W+2)'(34'sh80000000)) ? 32'sh80000000 :
                  sum[DIST_W-1:0];
    assign relax = (COUNT_W'(ea) < i_num_nodes) && (COUNT_W'(eb) < i_num_nodes)
                   && r_rch[ea] && (!r_rch[eb] || (r_dist[eb] > cand));

    assign o_pop    = (r_state == S_IDLE) && i_cmd_valid;
    assign o_idle   = (r_state == S_IDLE) && !i_cmd_valid;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_edges  <= '0;
            r_rch    <= '0;
            r_pv     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == S_EMIT);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.act == ACT_CLEAR) r_edges <= '0;
                        else if (we) r_edges <= r_edges + 1'b1;
                        else if (i_cmd.act == ACT_RUN) begin
                            r_rch <= (COUNT_W'(i_cmd.source_node) < i_num_nodes) ?
                                     (MAX_NODES'(1) << i_cmd.source_node) : '0;
                            r_pv  <= '0;
                            r_neg <= 1'b0;
                            r_node <= '0;
                            if (COUNT_W'(i_cmd.source_node) < i_num_nodes) begin
                                r_dist[i_cmd.source_node] <= '0;
                                r_state <= S_INIT;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                S_INIT: begin
                    r_eidx  <= '0;
                    r_pass  <= COUNT_W'(1);
                    r_check <= (i_num_nodes <= COUNT_W'(1));
                    r_state <= (r_edges == '0) ? S_EMIT : S_READ;
                end
                S_READ: r_state <= S_EVAL;
                S_EVAL: begin
                    if (relax) begin
                        if (r_check) r_neg <= 1'b1;
                        else begin
                            r_dist[eb] <= cand;
                            r_rch[eb]  <= 1'b1;
                            r_prev[eb] <= ea;
                            r_pv[eb]   <= 1'b1;
                        end
                    end
                    if (EC'(r_eidx) + 1'b1 == r_edges) begin
                        r_eidx <= '0;
                        if (r_check) r_state <= S_EMIT;
                        else begin
                            r_pass <= r_pass + 1'b1;
                            if (r_pass + 1'b1 == i_num_nodes) r_check <= 1'b1;
                            r_state <= S_READ;
                        end
                    end else begin
                        r_eidx  <= r_eidx + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_EMIT: begin
                    r_result.node_index      <= r_node;
                    r_result.distance        <= r_rch[r_node] ? r_dist[r_node] : UNREACHED_DIST;
                    r_result.predecessor     <= r_pv[r_node] ? r_prev[r_node] : '0;
                    r_result.has_predecessor <= r_pv[r_node];
                    r_result.reached         <= r_rch[r_node];
                    r_result.negative_cycle  <= r_neg;
                    r_result.last <= (COUNT_W'(r_node) + 1'b1 == i_num_nodes);
                    r_node <= r_node + 1'b1;
                    if (COUNT_W'(r_node) + 1'b1 == i_num_nodes) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> $past(r_state == S_READ))
        else $error("eval without read");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edges <= EC'(MAX_EDGES))
        else $error("edge count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_result.last) |-> (r_state == S_IDLE))
        else $error("emit past last node");
endmodule

### rtl/single_source_shortest_path_core.sv
// Top level of the single-source shortest path core.
// Depends on sssp_pkg, sssp_front, sssp_back.
//
// Usage: drive i_item with start; a beat is taken when start is high and
// busy low. Actions: clear edge list, append edge, run from source.
// A two-entry queue sits between front and back; busy is high while it is
// full. The back end pops one queued beat per idle cycle, so clears and
// appends retire one per cycle.
// A run on E stored edges and N nodes pops its beat, sets up, then reads
// and evaluates each edge in turn for N-1 relaxation passes and one check
// pass before its first result.
// A source outside the node range goes straight to the results.
// Results follow one per cycle, N in all, with o_strobe high;
// o_result.last marks the final node. Results cannot be stalled; later beats
// wait in the queue until the run is done.
// i_cfg_we writes the node count (clamped to 2..MAX_NODES); the user must write
// it only while idle (the block does not enforce this). Reset (synchronous,
// active low) empties the queue and the edge list and sets the node count to MAX_NODES; no clearing pass is needed.
module single_source_shortest_path_core #(
    parameter int unsigned MAX_EDGES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  sssp_pkg::t_in_item            i_item,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [sssp_pkg::COUNT_W-1:0]  i_cfg_data,
    output logic                          o_strobe,
    output sssp_pkg::t_out_item           o_result
);
    import sssp_pkg::*;

    logic [COUNT_W-1:0] r_num_nodes;
    logic cmd_valid, pop, idle;
    t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_nodes <= COUNT_W'(MAX_NODES);
        end else if (i_cfg_we) begin
            if (i_cfg_data < COUNT_W'(2))              r_num_nodes <= COUNT_W'(2);
            else if (i_cfg_data > COUNT_W'(MAX_NODES)) r_num_nodes <= COUNT_W'(MAX_NODES);
            else                                       r_num_nodes <= i_cfg_data;
        end
    end

    sssp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_item(i_item),
        .o_busy(busy), .i_pop(pop), .o_cmd_valid(cmd_valid), .o_cmd(cmd)
    );

    sssp_back #(.MAX_EDGES(MAX_EDGES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_num_nodes(r_num_nodes),
        .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_pop(pop), .o_idle(idle),
        .o_strobe(o_strobe), .o_result(o_result)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_num_nodes >= COUNT_W'(2)) && (r_num_nodes <= COUNT_W'(MAX_NODES)))
        else $error("node count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !idle || !cmd_valid)
        else $error("strobe inconsistent");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.reached) |-> (o_result.distance == UNREACHED_DIST))
        else $error("unreached distance wrong");
endmodule

### sim/tb_single_source_shortest_path_core.sv
// Self-checking testbench for single_source_shortest_path_core: edge loads,
// clears and Bellman-Ford runs checked beat by beat against an in-bench model.
// Depends on sssp_pkg and the core RTL.
module tb_single_source_shortest_path_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sssp_pkg::*;

    localparam int NODES_MAX = 32;
    localparam int EDGES_MAX = 256;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    t_in_item            i_item = '0;
    logic                busy;
    logic                i_cfg_we = 1'b0;
    logic [COUNT_W-1:0]  i_cfg_data = '0;
    logic                o_strobe;
    t_out_item           o_result;

    single_source_shortest_path_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    always #2 i_clk = ~i_clk;

    t_in_item  cmd_q[$];
    t_out_item path_q[$];
    int        errors = 0;
    int        gap = 0;
    bit        no_gaps = 0;
    longint    cycles = 0;

    // graph model state
    int        node_cnt = 32;
    int        edge_cnt = 0;
    int        e_tail[EDGES_MAX];
    int        e_head[EDGES_MAX];
    int        e_wt[EDGES_MAX];
    longint    node_dist[NODES_MAX];
    int        prev[NODES_MAX];
    bit        prev_ok[NODES_MAX];
    bit        reach[NODES_MAX];

    function automatic bit relax_edge(int e, bit apply);
        int a;
        int b;
        longint cand;
        a = e_tail[e];
        b = e_head[e];
        if (a >= node_cnt || b >= node_cnt) return 0;
        if (!reach[a]) return 0;
        cand = node_dist[a] + e_wt[e];
        if (cand > 64'sd2147483647) cand = 64'sd2147483647;
        if (cand < -64'sd2147483648) cand = -64'sd2147483648;
        if (reach[b] && !(node_dist[b] > cand)) return 0;
        if (apply) begin
            node_dist[b] = cand;
            reach[b] = 1;
            prev[b] = a;
            prev_ok[b] = 1;
        end
        return 1;
    endfunction

    function automatic void model_item(t_in_item it);
        bit neg;
        int src;
        t_out_item r;
        neg = 0;
        case (t_action'(it.action))
            ACT_CLEAR: edge_cnt = 0;
            ACT_APPEND: begin
                if (edge_cnt < EDGES_MAX) begin
                    e_tail[edge_cnt] = int'(it.from_node);
                    e_head[edge_cnt] = int'(it.to_node);
                    e_wt[edge_cnt] = int'(it.weight);
                    edge_cnt++;
                end
            end
            ACT_RUN: begin
                src = int'(it.source_node);
                for (int i = 0; i < NODES_MAX; i++) begin
                    node_dist[i] = 0;
                    prev[i] = 0;
                    prev_ok[i] = 0;
                    reach[i] = 0;
                end
                if (src < node_cnt) begin
                    reach[src] = 1;
                    for (int p = 1; p < node_cnt; p++)
                        for (int e = 0; e < edge_cnt; e++)
                            void'(relax_edge(e, 1));
                    for (int e = 0; e < edge_cnt; e++)
                        if (relax_edge(e, 0)) neg = 1;
                end
                for (int i = 0; i < node_cnt; i++) begin
                    r.node_index = NODE_BITS'(i);
                    r.distance = reach[i] ? 32'(node_dist[i]) : UNREACHED_DIST;
                    r.predecessor = prev_ok[i] ? NODE_BITS'(prev[i]) : '0;
                    r.has_predecessor = prev_ok[i];
                    r.reached = reach[i];
                    r.negative_cycle = neg;
                    r.last = (i + 1 == node_cnt);
                    path_q.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item mk(t_action act, int f, int t, int w, int s);
        t_in_item it;
        it.action = act;
        it.from_node = NODE_BITS'(f);
        it.to_node = NODE_BITS'(t);
        it.weight = WEIGHT_W'(w);
        it.source_node = NODE_BITS'(s);
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) model_item(i_item);
            if (!start || !busy) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    start <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    start <= 1'b1;
                    i_item <= cmd_q.pop_front();
                    gap <= pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name,
                     $signed(exp_v), $signed(got_v));
            errors++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (path_q.size() == 0) begin
                $display("%0t: unexpected beat, actual node %0d", $realtime,
                         o_result.node_index);
                errors++;
            end else begin
                want = path_q.pop_front();
                check_field("node_index", want.node_index, o_result.node_index);
                check_field("distance", want.distance, o_result.distance);
                check_field("predecessor", want.predecessor, o_result.predecessor);
                check_field("has_predecessor", want.has_predecessor,
                            o_result.has_predecessor);
                check_field("reached", want.reached, o_result.reached);
                check_field("negative_cycle", want.negative_cycle, o_result.negative_cycle);
                check_field("last", want.last, o_result.last);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // all beats taken and all expected results seen, sampled once signals settle
    task automatic drain();
        do @(negedge i_clk);
        while (cmd_q.size() != 0 || start || path_q.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_count(int v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= COUNT_W'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        node_cnt = (v < 2) ? 2 : (v > NODES_MAX) ? NODES_MAX : v;
    endtask

    function automatic int rand_weight();
        if ($urandom_range(9) == 0) return $signed(16'($urandom));
        return $urandom_range(40) - 8;
    endfunction

    task automatic random_phase(int n_items);
        int pushed;
        int k;
        int lim;
        pushed = 0;
        while (pushed < n_items) begin
            if ($urandom_range(9) == 0) begin
                cmd_q.push_back(mk(t_action'($urandom_range(3)), $urandom_range(31),
                                   $urandom_range(31), rand_weight(), $urandom_range(31)));
                pushed++;
                continue;
            end
            cmd_q.push_back(mk(ACT_CLEAR, 0, 0, 0, 0));
            k = $urandom_range(12);
            for (int j = 0; j < k; j++) begin
                lim = ($urandom_range(7) == 0) ? 31 : node_cnt - 1;
                cmd_q.push_back(mk(ACT_APPEND, $urandom_range(lim), $urandom_range(lim),
                                   rand_weight(), $urandom_range(31)));
            end
            lim = ($urandom_range(5) == 0) ? 31 : node_cnt - 1;
            cmd_q.push_back(mk(ACT_RUN, $urandom_range(31), $urandom_range(31),
                               $urandom(), $urandom_range(lim)));
            pushed += k + 2;
        end
    endtask

    initial begin
        int counts[8] = '{0, 1, 5, 63, 33, 2, 17, 32};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, empty list, negative cycle, out-of-range edges
        cmd_q.push_back(mk(ACT_RUN, 0, 0, 0, 0));
        cmd_q.push_back(mk(ACT_APPEND, 0, 1, -32768, 0));
        cmd_q.push_back(mk(ACT_APPEND, 1, 31, 32767, 31));
        cmd_q.push_back(mk(ACT_APPEND, 31, 2, 5, 0));
        cmd_q.push_back(mk(ACT_APPEND, 2, 3, -1, 0));
        cmd_q.push_back(mk(ACT_NONE, 31, 31, -1, 31));
        cmd_q.push_back(mk(ACT_RUN, 31, 31, -1, 0));
        cmd_q.push_back(mk(ACT_RUN, 0, 0, 0, 31));
        cmd_q.push_back(mk(ACT_CLEAR, 31, 31, -1, 31));
        cmd_q.push_back(mk(ACT_APPEND, 0, 1, -5, 0));
        cmd_q.push_back(mk(ACT_APPEND, 1, 0, 2, 0));
        cmd_q.push_back(mk(ACT_APPEND, 1, 2, 7, 0));
        cmd_q.push_back(mk(ACT_RUN, 0, 0, 0, 0));
        cmd_q.push_back(mk(ACT_RUN, 0, 0, 0, 2));
        drain();
        write_count(3);
        cmd_q.push_back(mk(ACT_APPEND, 2, 5, 1, 0));
        cmd_q.push_back(mk(ACT_APPEND, 5, 0, 1, 0));
        cmd_q.push_back(mk(ACT_RUN, 0, 0, 0, 2));
        cmd_q.push_back(mk(ACT_RUN, 0, 0, 0, 7));

        // edge list full, then one more append that must be dropped
        cmd_q.push_back(mk(ACT_CLEAR, 0, 0, 0, 0));
        for (int j = 0; j <= EDGES_MAX; j++)
            cmd_q.push_back(mk(ACT_APPEND, j % 3, (j + 1) % 3, j - 100, 0));
        cmd_q.push_back(mk(ACT_RUN, 0, 0, 0, 1));

        foreach (counts[p]) begin
            write_count(counts[p]);
            no_gaps = (p % 3 == 1);
            random_phase(10);
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (errors == 0 && path_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
